@@ hw/rtl/name_path_line_parser_core_defines.svh @@
// Assertion macros for the name/path line parser.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef NAME_PATH_LINE_PARSER_CORE_DEFINES_SVH
`define NAME_PATH_LINE_PARSER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define NPLP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define NPLP_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`else
`define NPLP_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define NPLP_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`endif

`endif

@@ hw/rtl/nplp_pkg.sv @@
// Shared constants and types for the name/path line parser.
// No dependencies; used by name_path_line_parser_core.
`timescale 1ns / 1ps

package nplp_pkg;

   localparam int NAME_LIMIT  = 64;   // 1..256
   localparam int PATH_LIMIT  = 256;  // 1..256
   localparam int ENTRY_LIMIT = 16;   // 1..16

   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_NUL   = 8'h00;

   typedef enum logic [1:0] {
      KIND_NAME_CHAR    = 2'd0,
      KIND_PATH_CHAR    = 2'd1,
      KIND_ENTRY_CLOSED = 2'd2,
      KIND_FINISHED     = 2'd3
   } kind_type;

   typedef struct packed {
      logic [4:0] entry_count;
      logic [7:0] char_value;
      logic [7:0] char_pos;
      logic [3:0] entry_index;
   } result_type;

endpackage

@@ hw/rtl/name_path_line_parser_core.sv @@
// Name/path line parser: turns a byte stream of "name,path" lines into
// character, entry-close and finish words. Depends on nplp_pkg and the
// assertion macros in name_path_line_parser_core_defines.svh.
`timescale 1ns / 1ps
`include "name_path_line_parser_core_defines.svh"

// The parser takes one text byte per clock and gives at most one result word
// for it. A byte passes an input register, then the mode update and result
// selection, then the result register, which drives rsp_*. Both registers
// advance together whenever the result register is empty or being drained,
// so a byte is accepted every cycle while rsp_tready is high, including
// while a finished result waits.
// Parsing stops after a NUL byte or after ENTRY_LIMIT entries have closed;
// later bytes are consumed silently until one arrives with req_tuser set,
// which restarts the parser on that byte.
module name_path_line_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tuser,   // [0] new_file
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [3:0] entry_index, [11:4] char_pos,
                                    // [19:12] char_value, [24:20] entry_count
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // done_res
);

   typedef enum logic [2:0] {
      MODE_NAME      = 3'd0,
      MODE_NAME_SKIP = 3'd1,
      MODE_COMMA_RUN = 3'd2,
      MODE_PATH      = 3'd3,
      MODE_PATH_SKIP = 3'd4,
      MODE_EOL_RUN   = 3'd5,
      MODE_DONE      = 3'd6
   } mode_type;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_new_ff;

   // parser state
   mode_type   mode_ff, mode_in;
   logic [4:0] count_ff, count_in;
   logic [8:0] pos_ff, pos_in;
   logic       started_ff, started_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   nplp_pkg::kind_type   rsp_kind_ff, rsp_kind_in;
   nplp_pkg::result_type rsp_data_ff, rsp_data_in;
   logic                 rsp_done_ff, rsp_done_in;

   logic advance;
   logic process;
   logic is_eol;
   logic is_comma;
   logic path_step;
   logic do_close;
   logic force_done;
   logic res_valid;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign process    = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   assign is_eol   = (in_byte_ff == nplp_pkg::CHAR_CR) || (in_byte_ff == nplp_pkg::CHAR_LF);
   assign is_comma = (in_byte_ff == nplp_pkg::CHAR_COMMA);

   always_comb begin
      mode_in     = mode_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      started_in  = started_ff;
      res_valid   = 1'b0;
      rsp_kind_in = nplp_pkg::KIND_NAME_CHAR;
      rsp_data_in = '0;
      rsp_done_in = 1'b0;
      path_step   = 1'b0;
      do_close    = 1'b0;
      force_done  = 1'b0;

      if (in_new_ff) begin
         mode_in    = MODE_NAME;
         count_in   = '0;
         pos_in     = '0;
         started_in = 1'b0;
      end

      if (mode_in != MODE_DONE) begin
         if (in_byte_ff == nplp_pkg::CHAR_NUL) begin
            if (started_in) begin
               do_close   = 1'b1;
               force_done = 1'b1;
            end else begin
               mode_in                 = MODE_DONE;
               res_valid               = 1'b1;
               rsp_kind_in             = nplp_pkg::KIND_FINISHED;
               rsp_data_in.entry_index = count_in[3:0];
               rsp_data_in.entry_count = count_in;
               rsp_done_in             = 1'b1;
            end
         end else begin
            // a non-line-end byte after a line end opens the next entry
            if (mode_in == MODE_EOL_RUN && !is_eol) begin
               mode_in = MODE_NAME;
               pos_in  = '0;
            end

            unique case (mode_in)
               MODE_NAME: begin
                  started_in = 1'b1;
                  if (is_comma) begin
                     mode_in = MODE_COMMA_RUN;
                  end else if (pos_in < 9'(nplp_pkg::NAME_LIMIT)) begin
                     res_valid               = 1'b1;
                     rsp_kind_in             = nplp_pkg::KIND_NAME_CHAR;
                     rsp_data_in.entry_index = count_in[3:0];
                     rsp_data_in.char_pos    = pos_in[7:0];
                     rsp_data_in.char_value  = in_byte_ff;
                     rsp_data_in.entry_count = count_in;
                     pos_in                  = pos_in + 9'd1;
                  end else begin
                     mode_in = MODE_NAME_SKIP;
                  end
               end
               MODE_NAME_SKIP: begin
                  if (is_comma) begin
                     mode_in = MODE_COMMA_RUN;
                  end
               end
               MODE_COMMA_RUN: begin
                  // first non-comma byte is already the first path byte
                  if (!is_comma) begin
                     pos_in    = '0;
                     path_step = 1'b1;
                  end
               end
               MODE_PATH: begin
                  path_step = 1'b1;
               end
               MODE_PATH_SKIP: begin
                  if (is_eol) begin
                     do_close = 1'b1;
                  end
               end
               default: begin
               end
            endcase

            if (path_step) begin
               mode_in = MODE_PATH;
               if (is_eol) begin
                  do_close = 1'b1;
               end else if (pos_in < 9'(nplp_pkg::PATH_LIMIT)) begin
                  res_valid               = 1'b1;
                  rsp_kind_in             = nplp_pkg::KIND_PATH_CHAR;
                  rsp_data_in.entry_index = count_in[3:0];
                  rsp_data_in.char_pos    = pos_in[7:0];
                  rsp_data_in.char_value  = in_byte_ff;
                  rsp_data_in.entry_count = count_in;
                  pos_in                  = pos_in + 9'd1;
               end else begin
                  mode_in = MODE_PATH_SKIP;
               end
            end
         end
      end

      if (do_close) begin
         rsp_data_in             = '0;
         rsp_data_in.entry_index = count_in[3:0];
         count_in                = count_in + 5'd1;
         started_in              = 1'b0;
         pos_in                  = '0;
         rsp_done_in             = force_done || (count_in >= 5'(nplp_pkg::ENTRY_LIMIT));
         mode_in                 = rsp_done_in ? MODE_DONE : MODE_EOL_RUN;
         res_valid               = 1'b1;
         rsp_kind_in             = nplp_pkg::KIND_ENTRY_CLOSED;
         rsp_data_in.entry_count = count_in;
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (process) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (process) begin
         rsp_valid_in = res_valid;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_NAME;
         count_ff     <= '0;
         pos_ff       <= '0;
         started_ff   <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (process) begin
            mode_ff    <= mode_in;
            count_ff   <= count_in;
            pos_ff     <= pos_in;
            started_ff <= started_in;
         end
      end

      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_new_ff  <= req_tuser;
      end
      if (process && res_valid) begin
         rsp_kind_ff <= rsp_kind_in;
         rsp_data_ff <= rsp_data_in;
         rsp_done_ff <= rsp_done_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff};
   assign rsp_tlast  = rsp_done_ff;

   `NPLP_ASSERT_IMPLY(a_finish_is_last, clock, reset,
      rsp_valid_ff && (rsp_kind_ff == nplp_pkg::KIND_FINISHED), rsp_done_ff,
      "finish word without done flag")
   `NPLP_ASSERT_IMPLY(a_last_kind, clock, reset, rsp_valid_ff && rsp_done_ff,
      (rsp_kind_ff == nplp_pkg::KIND_ENTRY_CLOSED) || (rsp_kind_ff == nplp_pkg::KIND_FINISHED),
      "done flag on a character word")
   `NPLP_ASSERT_IMPLY(a_done_closed, clock, reset, mode_ff == MODE_DONE, !started_ff,
      "entry still open after finish")
   `NPLP_ASSERT_ALWAYS(a_count_limit, clock, reset,
      count_ff <= 5'(nplp_pkg::ENTRY_LIMIT), "entry count past limit")

endmodule

@@ test/name_path_line_parser_core_tb.sv @@
// Self-checking bench for name_path_line_parser_core: random "name,path" files
// are streamed in and every result word is checked against an in-bench parser.
// Depends on nplp_pkg and the core RTL only.
`timescale 1ns / 1ps

module name_path_line_parser_core_tb;

   localparam int TARGET_BYTES = 1500;
   localparam int IDLE_LIMIT   = 1000;
   localparam int TAIL_CYCLES  = 8;

   typedef enum logic [2:0] {
      MODE_NAME,
      MODE_NAME_SKIP,
      MODE_COMMA_RUN,
      MODE_PATH,
      MODE_PATH_SKIP,
      MODE_EOL_RUN,
      MODE_DONE
   } parse_mode_type;

   typedef struct packed {
      nplp_pkg::kind_type kind;
      logic [3:0]         entry_index;
      logic [7:0]         char_pos;
      logic [7:0]         char_value;
      logic               done;
      logic [4:0]         entry_count;
   } parse_word_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       new_file;
      logic       drain;      // hold this byte until no result is outstanding
   } text_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] text_byte
   logic        req_tuser = 1'b0;  // [0] new_file
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [3:0] entry_index, [11:4] char_pos,
                                   // [19:12] char_value, [24:20] entry_count
   logic [1:0]  rsp_tuser;         // [1:0] kind
   logic        rsp_tlast;         // done_res

   name_path_line_parser_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   text_item_type  text_bytes[$];
   parse_word_type expected_words[$];

   // bench copy of the parser state
   parse_mode_type p_mode;
   logic [4:0]     p_closed;
   logic [8:0]     p_pos;
   logic           p_started;

   int fail_count = 0;
   int bytes_sent = 0;
   int words_checked = 0;
   int entries_closed_seen = 0;
   int finishes_seen = 0;
   int limit_hits = 0;
   int files_queued = 0;
   int ignored_bytes = 0;
   int idle_cycles = 0;

   logic start_flag = 1'b0;
   logic drain_flag = 1'b0;

   // ---------------------------------------------------------------- prediction

   task automatic push_word(input nplp_pkg::kind_type kind, input logic [3:0] idx,
                            input logic [7:0] pos, input logic [7:0] value,
                            input logic done, input logic [4:0] count);
      parse_word_type w;
      w.kind        = kind;
      w.entry_index = idx;
      w.char_pos    = pos;
      w.char_value  = value;
      w.done        = done;
      w.entry_count = count;
      expected_words.push_back(w);
   endtask

   task automatic close_entry(input logic force_done);
      logic [3:0] idx;
      logic       done;
      idx       = p_closed[3:0];
      p_closed  = p_closed + 5'd1;
      p_started = 1'b0;
      p_pos     = '0;
      done      = force_done || (p_closed >= nplp_pkg::ENTRY_LIMIT);
      if (done)
         p_mode = MODE_DONE;
      else
         p_mode = MODE_EOL_RUN;
      push_word(nplp_pkg::KIND_ENTRY_CLOSED, idx, 8'd0, 8'd0, done, p_closed);
   endtask

   task automatic advance_parser(input logic [7:0] b, input logic nf);
      logic is_eol;
      if (nf) begin
         p_mode    = MODE_NAME;
         p_closed  = '0;
         p_pos     = '0;
         p_started = 1'b0;
      end
      if (p_mode == MODE_DONE)
         return;
      if (b == nplp_pkg::CHAR_NUL) begin
         if (p_started) begin
            close_entry(1'b1);
         end else begin
            p_mode = MODE_DONE;
            push_word(nplp_pkg::KIND_FINISHED, p_closed[3:0], 8'd0, 8'd0, 1'b1, p_closed);
         end
         return;
      end
      is_eol = (b == nplp_pkg::CHAR_CR) || (b == nplp_pkg::CHAR_LF);
      if (p_mode == MODE_EOL_RUN) begin
         if (is_eol)
            return;
         p_mode = MODE_NAME;
         p_pos  = '0;
      end
      case (p_mode)
         MODE_NAME: begin
            p_started = 1'b1;
            if (b == nplp_pkg::CHAR_COMMA) begin
               p_mode = MODE_COMMA_RUN;
            end else if (p_pos < nplp_pkg::NAME_LIMIT) begin
               push_word(nplp_pkg::KIND_NAME_CHAR, p_closed[3:0], p_pos[7:0], b, 1'b0,
                         p_closed);
               p_pos = p_pos + 9'd1;
            end else begin
               p_mode = MODE_NAME_SKIP;
            end
            return;
         end
         MODE_NAME_SKIP: begin
            if (b == nplp_pkg::CHAR_COMMA)
               p_mode = MODE_COMMA_RUN;
            return;
         end
         MODE_COMMA_RUN: begin
            if (b == nplp_pkg::CHAR_COMMA)
               return;
            // first non-comma byte is already the first path byte
            p_mode = MODE_PATH;
            p_pos  = '0;
         end
         default: ;
      endcase
      if (is_eol) begin
         close_entry(1'b0);
      end else if (p_mode == MODE_PATH && p_pos < nplp_pkg::PATH_LIMIT) begin
         push_word(nplp_pkg::KIND_PATH_CHAR, p_closed[3:0], p_pos[7:0], b, 1'b0, p_closed);
         p_pos = p_pos + 9'd1;
      end else begin
         p_mode = MODE_PATH_SKIP;
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   task automatic queue_byte(input logic [7:0] b);
      text_item_type it;
      it.text_byte = b;
      it.new_file  = start_flag;
      it.drain     = drain_flag;
      text_bytes.push_back(it);
      start_flag = 1'b0;
      drain_flag = 1'b0;
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(1, 255));
      while (b == nplp_pkg::CHAR_COMMA || b == nplp_pkg::CHAR_CR || b == nplp_pkg::CHAR_LF);
      return b;
   endfunction

   function automatic logic [7:0] eol_byte();
      return ($urandom_range(0, 1) == 0) ? nplp_pkg::CHAR_CR : nplp_pkg::CHAR_LF;
   endfunction

   task automatic queue_file(input logic drain);
      int lines, name_len, path_len, k, j, ending;
      start_flag = 1'b1;
      drain_flag = drain;
      files_queued++;
      lines = ($urandom_range(0, 9) == 0)
              ? $urandom_range(nplp_pkg::ENTRY_LIMIT - 1, nplp_pkg::ENTRY_LIMIT + 2)
              : $urandom_range(0, 4);
      for (k = 0; k < lines; k++) begin
         name_len = ($urandom_range(0, 15) == 0)
                    ? $urandom_range(nplp_pkg::NAME_LIMIT - 2, nplp_pkg::NAME_LIMIT + 4)
                    : $urandom_range(0, 8);
         path_len = ($urandom_range(0, 24) == 0)
                    ? $urandom_range(nplp_pkg::PATH_LIMIT - 2, nplp_pkg::PATH_LIMIT + 4)
                    : $urandom_range(0, 12);
         // CR/LF inside a name are plain name bytes
         for (j = 0; j < name_len; j++)
            queue_byte(($urandom_range(0, 19) == 0) ? eol_byte() : plain_byte());
         repeat ($urandom_range(1, 3)) queue_byte(nplp_pkg::CHAR_COMMA);
         for (j = 0; j < path_len; j++)
            queue_byte(($urandom_range(0, 29) == 0) ? nplp_pkg::CHAR_COMMA : plain_byte());
         repeat ($urandom_range(1, 3)) queue_byte(eol_byte());
         if ($urandom_range(0, 19) == 0)
            queue_byte(8'($urandom_range(1, 255)));
      end
      ending = $urandom_range(0, 9);
      if (ending < 7) begin
         queue_byte(nplp_pkg::CHAR_NUL);
      end else if (ending < 9) begin
         // cut off inside a line
         repeat ($urandom_range(0, 4)) queue_byte(plain_byte());
         if ($urandom_range(0, 1) == 1) begin
            repeat ($urandom_range(1, 2)) queue_byte(nplp_pkg::CHAR_COMMA);
            repeat ($urandom_range(0, 4)) queue_byte(plain_byte());
         end
         queue_byte(nplp_pkg::CHAR_NUL);
      end
      // junk after the end of a file is dropped by the block
      if (ending < 9) begin
         j = $urandom_range(0, 3);
         repeat (j) queue_byte(8'($urandom_range(0, 255)));
         ignored_bytes += j;
      end
   endtask

   // ---------------------------------------------------------------- driver

   int            burst_left = 1;
   int            gap_left = 0;
   logic          req_fired = 1'b0;
   text_item_type next_item;

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fired) begin
         if (gap_left != 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (text_bytes.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (text_bytes[0].drain && expected_words.size() != 0) begin
            req_tvalid <= 1'b0;
         end else begin
            next_item = text_bytes.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_item.text_byte;
            req_tuser  <= next_item.new_file;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // result side back-pressure, switching between a few stall styles
   int rx_style = 0;
   int rx_style_left = 0;
   int rx_tick = 0;

   always @(negedge clock) begin
      if (rx_style_left == 0) begin
         rx_style      = $urandom_range(0, 3);
         rx_style_left = $urandom_range(32, 256);
      end else begin
         rx_style_left--;
      end
      rx_tick++;
      case (rx_style)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         2:       rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= ((rx_tick % 8) < 5);
      endcase
   end

   // ---------------------------------------------------------------- monitor

   function automatic void check_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         fail_count++;
      end
   endfunction

   parse_word_type want;

   always @(posedge clock) begin
      if (reset) begin
         req_fired   <= 1'b0;
         idle_cycles = 0;
         p_mode      = MODE_NAME;
         p_closed    = '0;
         p_pos       = '0;
         p_started   = 1'b0;
      end else begin
         req_fired <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected result word: kind %0d, tdata %h", rsp_tuser, rsp_tdata);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               check_field("kind", want.kind, rsp_tuser);
               check_field("entry_index", want.entry_index, rsp_tdata[3:0]);
               check_field("char_pos", want.char_pos, rsp_tdata[11:4]);
               check_field("char_value", want.char_value, rsp_tdata[19:12]);
               check_field("entry_count", want.entry_count, rsp_tdata[24:20]);
               check_field("done_res", want.done, rsp_tlast);
               words_checked++;
               if (want.kind == nplp_pkg::KIND_ENTRY_CLOSED)
                  entries_closed_seen++;
               if (want.done)
                  finishes_seen++;
               if (want.done && want.entry_count == nplp_pkg::ENTRY_LIMIT)
                  limit_hits++;
            end
         end
         // results are popped before the byte of this edge is predicted
         if (req_tvalid && req_tready) begin
            advance_parser(req_tdata, req_tuser);
            bytes_sent++;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("name_path_line_parser_core test failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      // empty file, then a byte after the finish
      start_flag = 1'b1;
      queue_byte(nplp_pkg::CHAR_NUL);
      queue_byte(8'hFF);
      // comma first, comma run, extreme path bytes, line end run
      start_flag = 1'b1;
      queue_byte(nplp_pkg::CHAR_COMMA);
      queue_byte(nplp_pkg::CHAR_COMMA);
      queue_byte(8'hFF);
      queue_byte(8'h01);
      queue_byte(nplp_pkg::CHAR_CR);
      queue_byte(nplp_pkg::CHAR_LF);
      // CR and LF inside a name, NUL in the middle of a path
      queue_byte(8'h80);
      queue_byte(nplp_pkg::CHAR_CR);
      queue_byte(nplp_pkg::CHAR_LF);
      queue_byte(nplp_pkg::CHAR_COMMA);
      queue_byte(8'h7F);
      queue_byte(nplp_pkg::CHAR_NUL);
      // NUL right after a line end
      start_flag = 1'b1;
      queue_byte(8'h71);
      queue_byte(nplp_pkg::CHAR_COMMA);
      queue_byte(8'h72);
      queue_byte(nplp_pkg::CHAR_LF);
      queue_byte(nplp_pkg::CHAR_NUL);
      // NUL inside the comma run
      start_flag = 1'b1;
      queue_byte(8'h7A);
      queue_byte(nplp_pkg::CHAR_COMMA);
      queue_byte(nplp_pkg::CHAR_NUL);

      queue_file(1'b1);
      while (text_bytes.size() - ignored_bytes < TARGET_BYTES)
         queue_file($urandom_range(0, 7) == 0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (text_bytes.size() == 0 && !req_tvalid);
      wait (expected_words.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d bytes in %0d files sent, %0d result words checked",
               bytes_sent, files_queued, words_checked);
      $display("%0d entries closed, %0d parses finished, %0d at the entry limit",
               entries_closed_seen, finishes_seen, limit_hits);
      if (fail_count == 0 && expected_words.size() == 0) begin
         $display("name_path_line_parser_core test passed");
      end else begin
         $display("name_path_line_parser_core test failed");
      end
      $finish;
   end

endmodule
